### hw/rtl/assert_macros.svh
// Assertion macros used by the cache top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/sac_lru_pkg.sv
// Constants and codes for the set-associative cache tag model.
`timescale 1ns / 1ps

package sac_lru_pkg;

  // age counter per line, saturating
  localparam int unsigned AGE_W   = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // configuration
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_TIME     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_PENALTY = 2'd2;

  localparam logic POLICY_LRU = 1'b0;
  localparam logic POLICY_LFU = 1'b1;

  // result fields
  localparam int unsigned WAY_OUT_W = 2;
  localparam int unsigned CNT_OUT_W = 32;
  localparam int unsigned CYC_OUT_W = 48;
  localparam int unsigned RES_W     = 1 + WAY_OUT_W + 2 * CNT_OUT_W + CYC_OUT_W;
  localparam int unsigned RES_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

### hw/rtl/set_assoc_cache_lru_lfu.sv
// Set-associative cache tag model with LRU or LFU replacement, top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one address per transaction and returns one result per transaction:
// hit flag, way (hit or filled), and running totals of accesses, misses and
// charged cycles. Sustained rate is one transaction per clock while m_tready
// stays high. Results pass stage A and the result register. The set's tags,
// ages and use histories live in one memory row per set, read when the
// address is accepted and written back as it leaves stage A; a same-set read
// in that clock gets the written row by forwarding. Valid bits
// sit in flip-flops cleared at reset, so the block is ready straight out of
// reset with no clearing pass. Tags, ages and histories of a way are only
// meaningful while its valid bit is set. Ages saturate at 65535. On a miss
// the lowest invalid way is filled; with a full set the victim is the
// oldest way (LRU) or the way with fewest ones in its history (LFU), lowest
// way winning ties. Configuration is written through cfg_we/cfg_index/
// cfg_data while the block is idle; a policy change applies from the next
// miss. Output fields are packed in m_tdata as listed beside the port.
module set_assoc_cache_lru_lfu #(
  parameter int unsigned SET_BITS      = 6,
  parameter int unsigned WAYS          = 4,
  parameter int unsigned OFFSET_BITS   = 4,
  parameter int unsigned ADDR_BITS     = 32,
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // address stream
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // [ADDR_BITS-1:0] address, zero padded to bytes
  input  logic [((ADDR_BITS + 7) / 8) * 8 - 1:0]   s_tdata,
  // result stream
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // [0] hit, [2:1] way, [34:3] total_accesses, [66:35] total_misses,
  // [114:67] total_cycles, zero padded to bytes
  output logic [sac_lru_pkg::RES_TDATA_W-1:0]      m_tdata,
  // configuration write port
  input  logic                                     cfg_we,
  input  logic [sac_lru_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sac_lru_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int unsigned NUM_SETS = 1 << SET_BITS;
  localparam int unsigned SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned WAY_IW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned IDX_BITS = SET_BITS + OFFSET_BITS;
  // zero or negative tag width collapses to a single bit that is always 0
  localparam int unsigned TAG_W    = (ADDR_BITS > IDX_BITS) ? ADDR_BITS - IDX_BITS : 1;
  localparam int unsigned ONES_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned AGE_W    = sac_lru_pkg::AGE_W;
  localparam int unsigned CNT_W    = sac_lru_pkg::CNT_OUT_W;
  localparam int unsigned CYC_W    = sac_lru_pkg::CYC_OUT_W;
  localparam logic [SET_IW-1:0] SET_MASK = SET_IW'(NUM_SETS - 1);

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic [AGE_W-1:0]         age;
    logic [HISTORY_DEPTH-1:0] hist;   // bit HISTORY_DEPTH-1 is the newest
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic                                policy;
  logic [sac_lru_pkg::CFG_DATA_W-1:0]  hit_time;
  logic [sac_lru_pkg::CFG_DATA_W-1:0]  miss_penalty;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= sac_lru_pkg::POLICY_LRU;
      hit_time     <= '0;
      miss_penalty <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sac_lru_pkg::REG_POLICY:       policy       <= cfg_data[0];
        sac_lru_pkg::REG_HIT_TIME:     hit_time     <= cfg_data;
        sac_lru_pkg::REG_MISS_PENALTY: miss_penalty <= cfg_data;
        default: ;                     // no register at this index
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshake: lookup stage A feeds the result register
  // ---------------------------------------------------------------------
  logic a_valid;
  logic a_adv;     // stage A completes its transaction this clock
  logic s_acc;     // new address accepted this clock

  assign a_adv    = a_valid && (!m_tvalid || m_tready);
  assign s_tready = !a_valid || a_adv;
  assign s_acc    = s_tvalid && s_tready;

  logic [ADDR_BITS-1:0] in_addr;
  logic [SET_IW-1:0]    in_set;
  assign in_addr = s_tdata[ADDR_BITS-1:0];
  assign in_set  = SET_IW'(in_addr >> OFFSET_BITS) & SET_MASK;

  logic [ADDR_BITS-1:0] a_addr;
  logic [SET_IW-1:0]    a_set;
  logic [TAG_W-1:0]     a_tag;
  assign a_set = SET_IW'(a_addr >> OFFSET_BITS) & SET_MASK;
  assign a_tag = TAG_W'(a_addr >> IDX_BITS);

  // ---------------------------------------------------------------------
  // set memory and forwarding
  // ---------------------------------------------------------------------
  row_t set_mem [NUM_SETS];
  row_t rd_row;
  row_t fwd_row;
  logic fwd;
  row_t row_next;

  always_ff @(posedge clk) begin
    if (s_acc) begin
      rd_row <= set_mem[in_set];
    end
    if (a_adv) begin
      set_mem[a_set] <= row_next;
    end
  end

  // read and write of the same set in one clock: the read sees the old row
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (s_acc) begin
      fwd <= a_adv && (a_set == in_set);
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && a_adv) begin
      fwd_row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      a_addr <= in_addr;
    end
  end

  // valid bits, one per line
  logic [WAYS-1:0] valid_q [NUM_SETS];
  logic [WAYS-1:0] vrow;
  logic [WAYS-1:0] vrow_next;
  assign vrow = valid_q[a_set];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_q[s] <= '0;
      end
    end else if (a_adv) begin
      valid_q[a_set] <= vrow_next;
    end
  end

  // ---------------------------------------------------------------------
  // lookup, update and victim choice
  // ---------------------------------------------------------------------
  row_t                    row_cur;
  logic [WAYS-1:0]         match;
  logic [WAYS-1:0]         fill;
  logic [ONES_W-1:0]       ones [WAYS];
  logic                    hit;
  logic                    any_inv;
  logic [WAY_IW-1:0]       hit_way;
  logic [WAY_IW-1:0]       inv_way;
  logic [WAY_IW-1:0]       lru_way;
  logic [WAY_IW-1:0]       lfu_way;
  logic [WAY_IW-1:0]       way_sel;
  logic [AGE_W-1:0]        best_age;
  logic [ONES_W-1:0]       best_ones;

  always_comb begin
    logic [HISTORY_DEPTH-1:0] hist_sh;
    logic [AGE_W-1:0]         age_inc;

    row_cur  = fwd ? fwd_row : rd_row;
    row_next = row_cur;
    hist_sh  = '0;
    age_inc  = '0;

    for (int w = 0; w < WAYS; w++) begin
      match[w] = vrow[w] && (row_cur[w].tag == a_tag);
      age_inc  = (row_cur[w].age == sac_lru_pkg::AGE_MAX) ? row_cur[w].age
                                                          : row_cur[w].age + 1'b1;
      hist_sh  = row_cur[w].hist >> 1;
      hist_sh[HISTORY_DEPTH-1] = match[w];
      row_next[w].age = match[w] ? '0 : age_inc;
      if (vrow[w]) begin
        row_next[w].hist = hist_sh;
      end
      ones[w] = ONES_W'($countones(hist_sh));
    end

    hit = |match;

    // lowest matching way and lowest invalid way
    hit_way = '0;
    inv_way = '0;
    any_inv = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_IW'(w);
      end
      if (!vrow[w]) begin
        inv_way = WAY_IW'(w);
        any_inv = 1'b1;
      end
    end

    // full set: strict compares keep the lowest way on ties
    lru_way   = '0;
    best_age  = row_next[0].age;
    lfu_way   = '0;
    best_ones = ones[0];
    for (int w = 1; w < WAYS; w++) begin
      if (row_next[w].age > best_age) begin
        best_age = row_next[w].age;
        lru_way  = WAY_IW'(w);
      end
      if (ones[w] < best_ones) begin
        best_ones = ones[w];
        lfu_way   = WAY_IW'(w);
      end
    end

    priority if (hit) begin
      way_sel = hit_way;
    end else if (any_inv) begin
      way_sel = inv_way;
    end else if (policy == sac_lru_pkg::POLICY_LFU) begin
      way_sel = lfu_way;
    end else begin
      way_sel = lru_way;
    end

    // fill: fresh age, history holding just the newest access
    for (int w = 0; w < WAYS; w++) begin
      fill[w] = !hit && (way_sel == WAY_IW'(w));
      if (fill[w]) begin
        row_next[w].tag  = a_tag;
        row_next[w].age  = '0;
        row_next[w].hist = '0;
        row_next[w].hist[HISTORY_DEPTH-1] = 1'b1;
      end
    end

    vrow_next = vrow | fill;
  end

  // ---------------------------------------------------------------------
  // running totals and result register
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] access_count;
  logic [CNT_W-1:0] miss_count;
  logic [CYC_W-1:0] cycle_total;
  logic [CNT_W-1:0] access_count_next;
  logic [CNT_W-1:0] miss_count_next;
  logic [CYC_W-1:0] cycle_total_next;

  assign access_count_next = access_count + 1'b1;
  assign miss_count_next   = hit ? miss_count : miss_count + 1'b1;
  assign cycle_total_next  = cycle_total + CYC_W'(hit_time)
                           + (hit ? '0 : CYC_W'(miss_penalty));

  always_ff @(posedge clk) begin
    if (rst) begin
      access_count <= '0;
      miss_count   <= '0;
      cycle_total  <= '0;
    end else if (a_adv) begin
      access_count <= access_count_next;
      miss_count   <= miss_count_next;
      cycle_total  <= cycle_total_next;
    end
  end

  logic                                 out_hit;
  logic [sac_lru_pkg::WAY_OUT_W-1:0]    out_way;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (a_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_hit <= hit;
      out_way <= sac_lru_pkg::WAY_OUT_W'(way_sel);
    end
  end

  // totals registers already hold the values after this transaction
  assign m_tdata = {{(sac_lru_pkg::RES_TDATA_W - sac_lru_pkg::RES_W){1'b0}},
                    cycle_total, miss_count, access_count, out_way, out_hit};

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `ASSERT_CLK(a_fill_onehot, a_adv && !hit |-> $onehot(fill),
              "miss must fill exactly one way")
  `ASSERT_CLK(a_no_fill_on_hit, hit |-> (fill == '0), "hit must not fill a way")
  `ASSERT_CLK(a_access_inc, a_adv |=> access_count == $past(access_count) + 1'b1,
              "access total not advanced")
  `ASSERT_CLK(a_miss_inc, a_adv && !hit |=> miss_count == $past(miss_count) + 1'b1,
              "miss total not advanced")
  `ASSERT_CLK(a_way_valid_after, a_adv |=> valid_q[$past(a_set)][$past(way_sel)],
              "selected way not valid after update")

endmodule

### tb/sv/set_assoc_cache_lru_lfu_chk.sv
// Scoreboard for the set-associative cache: tracks the tag array, predicts each lookup, checks results.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lfu_chk #(
  parameter int unsigned SET_BITS      = 6,
  parameter int unsigned WAYS          = 4,
  parameter int unsigned OFFSET_BITS   = 4,
  parameter int unsigned ADDR_BITS     = 32,
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  input  logic                                   s_tready,
  input  logic [((ADDR_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                   m_tvalid,
  input  logic                                   m_tready,
  input  logic [sac_lru_pkg::RES_TDATA_W-1:0]    m_tdata,
  input  logic                                   cfg_we,
  input  logic [sac_lru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sac_lru_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                     mismatches,
  output int                                     results_seen,
  output int                                     hit_total,
  output int                                     miss_total,
  output int                                     lru_evictions,
  output int                                     lfu_evictions
);
  import sac_lru_pkg::*;

  localparam int unsigned NUM_SETS = 1 << SET_BITS;
  localparam int unsigned TAG_W    = ADDR_BITS - SET_BITS - OFFSET_BITS;

  typedef struct packed {
    logic [CYC_OUT_W-1:0] cycles;
    logic [CNT_OUT_W-1:0] misses;
    logic [CNT_OUT_W-1:0] accesses;
    logic [WAY_OUT_W-1:0] way;
    logic                 hit;
  } lookup_result_t;

  // shadow tag array
  logic                     line_valid [NUM_SETS][WAYS];
  logic [TAG_W-1:0]         line_tag   [NUM_SETS][WAYS];
  logic [AGE_W-1:0]         line_age   [NUM_SETS][WAYS];
  logic [HISTORY_DEPTH-1:0] line_hist  [NUM_SETS][WAYS];  // bit 0 newest

  logic [CNT_OUT_W-1:0]  access_cnt;
  logic [CNT_OUT_W-1:0]  miss_cnt;
  logic [CYC_OUT_W-1:0]  cycle_sum;
  logic                  cur_policy;
  logic [CFG_DATA_W-1:0] cur_hit_time;
  logic [CFG_DATA_W-1:0] cur_miss_penalty;

  lookup_result_t pending_lookups[$];
  lookup_result_t got_res;
  lookup_result_t want_res;

  function automatic lookup_result_t lookup_access(logic [ADDR_BITS-1:0] addr);
    logic [SET_BITS-1:0] set_idx;
    logic [TAG_W-1:0]    tag_val;
    logic                hit_f;
    logic                found;
    int                  way_sel;
    int                  best;
    int                  ones;
    lookup_result_t      res;
    set_idx = addr[OFFSET_BITS +: SET_BITS];
    tag_val = addr[ADDR_BITS-1 -: TAG_W];
    hit_f   = 1'b0;
    way_sel = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (line_age[set_idx][w] != AGE_MAX) line_age[set_idx][w]++;
      if (line_valid[set_idx][w]) begin
        if (line_tag[set_idx][w] == tag_val) begin
          line_age[set_idx][w]  = '0;
          line_hist[set_idx][w] = {line_hist[set_idx][w][HISTORY_DEPTH-2:0], 1'b1};
          if (!hit_f) way_sel = w;
          hit_f = 1'b1;
        end else begin
          line_hist[set_idx][w] = {line_hist[set_idx][w][HISTORY_DEPTH-2:0], 1'b0};
        end
      end
    end
    if (!hit_f) begin
      found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !line_valid[set_idx][w]) begin
          way_sel = w;
          found   = 1'b1;
        end
      end
      if (!found) begin
        way_sel = 0;
        if (cur_policy == POLICY_LRU) begin
          for (int w = 1; w < WAYS; w++)
            if (line_age[set_idx][w] > line_age[set_idx][way_sel]) way_sel = w;
          lru_evictions++;
        end else begin
          best = $countones(line_hist[set_idx][0]);
          for (int w = 1; w < WAYS; w++) begin
            ones = $countones(line_hist[set_idx][w]);
            if (ones < best) begin
              best    = ones;
              way_sel = w;
            end
          end
          lfu_evictions++;
        end
      end
      line_valid[set_idx][way_sel] = 1'b1;
      line_tag[set_idx][way_sel]   = tag_val;
      line_age[set_idx][way_sel]   = '0;
      line_hist[set_idx][way_sel]  = HISTORY_DEPTH'(1);
    end
    access_cnt++;
    cycle_sum = cycle_sum + CYC_OUT_W'(cur_hit_time);
    if (hit_f) begin
      hit_total++;
    end else begin
      miss_cnt++;
      miss_total++;
      cycle_sum = cycle_sum + CYC_OUT_W'(cur_miss_penalty);
    end
    res.hit      = hit_f;
    res.way      = WAY_OUT_W'(way_sel);
    res.accesses = access_cnt;
    res.misses   = miss_cnt;
    res.cycles   = cycle_sum;
    return res;
  endfunction

  function automatic void check_field(string name, logic [CYC_OUT_W-1:0] want_v,
                                      logic [CYC_OUT_W-1:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_valid[s][w] = 1'b0;
          line_tag[s][w]   = '0;
          line_age[s][w]   = '0;
          line_hist[s][w]  = '0;
        end
      end
      access_cnt       = '0;
      miss_cnt         = '0;
      cycle_sum        = '0;
      cur_policy       = POLICY_LRU;
      cur_hit_time     = '0;
      cur_miss_penalty = '0;
      pending_lookups.delete();
      mismatches    = 0;
      hit_total     = 0;
      miss_total    = 0;
      lru_evictions = 0;
      lfu_evictions = 0;
      results_seen <= 0;
    end else begin
      // compare before pushing, so a result cannot match a lookup taken in the same cycle
      if (m_tvalid && m_tready) begin
        got_res = lookup_result_t'(m_tdata[RES_W-1:0]);
        if (pending_lookups.size() == 0) begin
          $error("result transaction with no lookup outstanding: 0x%0h", got_res);
          mismatches++;
        end else begin
          want_res = pending_lookups.pop_front();
          check_field("hit", want_res.hit, got_res.hit);
          check_field("way", want_res.way, got_res.way);
          check_field("total_accesses", want_res.accesses, got_res.accesses);
          check_field("total_misses", want_res.misses, got_res.misses);
          check_field("total_cycles", want_res.cycles, got_res.cycles);
        end
        results_seen <= results_seen + 1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY:       cur_policy       = cfg_data[0];
          REG_HIT_TIME:     cur_hit_time     = cfg_data;
          REG_MISS_PENALTY: cur_miss_penalty = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        pending_lookups.push_back(lookup_access(s_tdata[ADDR_BITS-1:0]));
    end
  end

endmodule

### tb/sv/set_assoc_cache_lru_lfu_tb.sv
// Testbench top for the set-associative cache: lookup stimulus, flow control and verdict.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lfu_tb;
  import sac_lru_pkg::*;

  localparam int unsigned SET_BITS      = 6;
  localparam int unsigned WAYS          = 4;
  localparam int unsigned OFFSET_BITS   = 4;
  localparam int unsigned ADDR_BITS     = 32;
  localparam int unsigned HISTORY_DEPTH = 16;
  localparam int unsigned TAG_W         = ADDR_BITS - SET_BITS - OFFSET_BITS;
  localparam int unsigned S_DATA_W      = ((ADDR_BITS + 7) / 8) * 8;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int HOLD_CYCLES    = 80;     // long receiver stall, fills the pipe
  localparam int PHASE_ITEMS    = 190;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata;      // [31:0] address
  logic                   m_tvalid;
  logic                   m_tready;
  // [0] hit, [2:1] way, [34:3] total_accesses, [66:35] total_misses, [114:67] total_cycles
  logic [RES_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int results_seen;
  int hit_total;
  int miss_total;
  int lru_evictions;
  int lfu_evictions;

  int items_sent;
  int cycle_cnt;
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;

  // per-phase working set: few sets and a handful of tags, so lines get reused and evicted
  logic [TAG_W-1:0]    tag_pool [6];
  logic [SET_BITS-1:0] set_pool [3];

  set_assoc_cache_lru_lfu #(
    .SET_BITS     (SET_BITS),
    .WAYS         (WAYS),
    .OFFSET_BITS  (OFFSET_BITS),
    .ADDR_BITS    (ADDR_BITS),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  set_assoc_cache_lru_lfu_chk #(
    .SET_BITS     (SET_BITS),
    .WAYS         (WAYS),
    .OFFSET_BITS  (OFFSET_BITS),
    .ADDR_BITS    (ADDR_BITS),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_chk (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_seen (results_seen),
    .hit_total    (hit_total),
    .miss_total   (miss_total),
    .lru_evictions(lru_evictions),
    .lfu_evictions(lfu_evictions)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $error("run did not complete within %0d cycles", CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Result side. Random stall bursts while enabled, plus one long hold-off on request
  // so the lookup side backs up and has to stall.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [ADDR_BITS-1:0] compose_address(logic [TAG_W-1:0] tag_v,
                                                           logic [SET_BITS-1:0] set_v,
                                                           logic [OFFSET_BITS-1:0] off_v);
    return {tag_v, set_v, off_v};
  endfunction

  // One lookup transaction. tvalid is left high on return so back-to-back
  // lookups go out without a bubble; a gap, if drawn, is inserted first.
  task automatic send_lookup(input logic [ADDR_BITS-1:0] addr);
    int gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'(addr);
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Stop offering and wait until every lookup has produced its result.
  // One result per lookup, so nothing is still in flight afterwards; the
  // extra cycles just cover the pipeline depth.
  task automatic drain_lookups();
    s_tvalid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Registers only change with the block idle.
  task automatic apply_settings(input logic pol, input logic [CFG_DATA_W-1:0] hit_cyc,
                                input logic [CFG_DATA_W-1:0] miss_cyc);
    drain_lookups();
    cfg_we    <= 1'b1;
    cfg_index <= REG_POLICY;
    cfg_data  <= CFG_DATA_W'(pol);
    @(posedge clk);
    cfg_index <= REG_HIT_TIME;
    cfg_data  <= hit_cyc;
    @(posedge clk);
    cfg_index <= REG_MISS_PENALTY;
    cfg_data  <= miss_cyc;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic directed_lookups();
    // LRU: fill set 0, hit, then force an eviction of the stalest way
    apply_settings(POLICY_LRU, CFG_DATA_W'(5), CFG_DATA_W'(20));
    send_lookup(compose_address('0, '0, '0));
    send_lookup(compose_address('1, '0, '1));
    send_lookup(compose_address(TAG_W'(1), '0, '0));
    send_lookup(compose_address(TAG_W'(2), '0, OFFSET_BITS'(7)));
    send_lookup(compose_address('0, '0, OFFSET_BITS'(3)));   // hit on way 0
    send_lookup(compose_address(TAG_W'(3), '0, '0));         // full set, evicts oldest
    send_lookup(compose_address('1, '0, '0));                 // evicted tag comes back
    send_lookup('1);                                          // top set, all-ones tag
    send_lookup('1);                                          // same set back to back
    // LFU: set 1 gets uneven use, then a miss has to pick the least used way
    apply_settings(POLICY_LFU, CFG_DATA_W'(999), CFG_DATA_W'(999));
    for (int w = 0; w < WAYS; w++)
      send_lookup(compose_address(TAG_W'(4 + w), SET_BITS'(1), '0));
    send_lookup(compose_address(TAG_W'(6), SET_BITS'(1), '0));
    send_lookup(compose_address(TAG_W'(6), SET_BITS'(1), '1));
    send_lookup(compose_address(TAG_W'(7), SET_BITS'(1), '0));
    send_lookup(compose_address(TAG_W'(4), SET_BITS'(1), '0));
    send_lookup(compose_address(TAG_W'(8), SET_BITS'(1), '0));
    send_lookup(compose_address(TAG_W'(5), SET_BITS'(1), '0));
    send_lookup(compose_address(TAG_W'(8), SET_BITS'(1), '0));
  endtask

  // Random traffic, mostly within a small working set so hits and evictions
  // dominate; the rest is full-range noise.
  task automatic random_phase(input int phase_no, input logic pol,
                              input logic [CFG_DATA_W-1:0] hit_cyc,
                              input logic [CFG_DATA_W-1:0] miss_cyc);
    int                   t_idx;
    logic [ADDR_BITS-1:0] addr;
    apply_settings(pol, hit_cyc, miss_cyc);
    for (int i = 0; i < 6; i++) tag_pool[i] = TAG_W'($urandom());
    tag_pool[0] = phase_no[0] ? '1 : '0;
    set_pool[0] = phase_no[0] ? '1 : '0;
    set_pool[1] = SET_BITS'($urandom());
    set_pool[2] = SET_BITS'($urandom());
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (phase_no == 1 && k == 60) hold_req = 1'b1;
      if (phase_no == 2 && k == 90) drain_lookups();
      if ($urandom_range(0, 99) < 85) begin
        // skew towards the first two tags so use counts differ
        t_idx = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, 5);
        addr  = compose_address(tag_pool[t_idx], set_pool[$urandom_range(0, 2)],
                                OFFSET_BITS'($urandom()));
      end else begin
        addr = ADDR_BITS'($urandom());
      end
      send_lookup(addr);
    end
  endtask

  initial begin
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_POLICY;
    cfg_data   <= '0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    hold_req    = 1'b0;
    items_sent  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_lookups();

    random_phase(0, POLICY_LRU, CFG_DATA_W'(0), CFG_DATA_W'(0));
    random_phase(1, POLICY_LFU, CFG_DATA_W'(999), CFG_DATA_W'(999));
    random_phase(2, POLICY_LRU, CFG_DATA_W'($urandom_range(0, 999)),
                 CFG_DATA_W'($urandom_range(0, 999)));
    random_phase(3, POLICY_LFU, CFG_DATA_W'(0), CFG_DATA_W'($urandom_range(0, 999)));
    random_phase(4, POLICY_LFU, CFG_DATA_W'($urandom_range(0, 999)), CFG_DATA_W'(0));
    // closing stretch at full rate on both sides
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_phase(5, POLICY_LRU, CFG_DATA_W'(999), CFG_DATA_W'(999));

    s_tvalid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (10) @(posedge clk);   // any stray result would show up here

    $display("Checked %0d lookup transactions: %0d hits, %0d misses.",
             items_sent, hit_total, miss_total);
    $display("Evictions: %0d by age, %0d by use count; both policies, costs 0 to 999.",
             lru_evictions, lfu_evictions);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
